// ===== hw/rtl/fba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the FAT block allocator
// Block geometry, command and status codes, the controller state type and
// the control bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int NUM_BLOCKS       = 256;
    localparam int FIRST_DATA_BLOCK = 3;
    localparam int BLK_W            = $clog2(NUM_BLOCKS);

    localparam int CMD_W    = 3;
    localparam int IN_BLK_W = 9;
    localparam int TGT_W    = 8;
    localparam int RES_W    = 8;
    localparam int CNT_W    = 9;
    localparam int NEXT_W   = TGT_W + 1;
    localparam int END_BIT  = NEXT_W - 1;

    // Free search: groups of GRP_SIZE bits; the lowest group with a free bit is picked
    localparam int GRP_POS_W  = 4;
    localparam int GRP_SIZE   = 1 << GRP_POS_W;
    localparam int NUM_GROUPS = (NUM_BLOCKS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_IDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W      = NUM_GROUPS * GRP_SIZE;

    localparam logic [NEXT_W-1:0] END_VAL    = NEXT_W'(1 << END_BIT);
    localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(NUM_BLOCKS - FIRST_DATA_BLOCK);
    localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(NUM_BLOCKS);
    localparam logic [NUM_BLOCKS-1:0] USED_RESET =
        NUM_BLOCKS'((1 << FIRST_DATA_BLOCK) - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_FREE   = 3'd2,
        CMD_LINK   = 3'd3,
        CMD_NEXT   = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FREE    = 2'd2,
        ST_NOSPACE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
    } t_dp_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/fba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl: command sequencer
// Takes an item, runs the lookup cycle and the execute cycle, and lets the
// next item in during the execute cycle.
// ----------------------------------------------------------------------------
module fba_ctrl import fba_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    output t_dp_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        busy          = (r_state == S_LOOKUP) || !i_rst_n;
        o_ctl         = '0;
        o_ctl.capture = start && !busy;
        unique case (r_state)
            S_IDLE: begin
                if (o_ctl.capture) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_ctl.lookup = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = o_ctl.capture ? S_LOOKUP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fba_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fba_datapath: allocation table, chain memory and free count
// Used bitmap in flops, next-pointer memory with per-entry valid bits,
// two-level first-free search and the registered result.
// ----------------------------------------------------------------------------
module fba_datapath import fba_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_ctl             i_ctl,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [IN_BLK_W-1:0] i_block,
    input  wire logic [TGT_W-1:0]    i_link_target,
    input  wire logic                i_link_is_end,
    output logic                     o_valid,
    output logic [RES_W-1:0]         o_result_block,
    output logic                     o_result_is_end,
    output logic                     o_used,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_free_count
);

    logic [CMD_W-1:0]     r_cmd;
    logic [IN_BLK_W-1:0]  r_blk;
    logic [TGT_W-1:0]     r_tgt;
    logic                 r_is_end;

    logic [NUM_BLOCKS-1:0] r_used;
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [NEXT_W-1:0]     next_mem [NUM_BLOCKS];
    logic [NEXT_W-1:0]     r_rd_data;
    logic [CNT_W-1:0]      r_free_cnt;

    logic [GRP_IDX_W-1:0]  r_grp;
    logic [GRP_IDX_W-1:0]  n_grp;
    logic                  r_any;
    logic                  n_any;

    logic                  r_out_valid;
    logic [RES_W-1:0]      r_res_block;
    logic                  r_res_end;
    logic                  r_res_used;
    t_status               r_res_status;

    logic [PAD_W-1:0]      free_vec;
    logic [NUM_GROUPS-1:0] grp_any;
    logic [GRP_SIZE-1:0]   grp_bits;
    logic [GRP_POS_W-1:0]  pos;
    logic [BLK_W-1:0]      alloc_idx;
    logic [BLK_W-1:0]      blk_a;
    logic                  in_range;
    logic                  is_sys;
    logic [NEXT_W-1:0]     stored_next;

    logic [RES_W-1:0]      res_block;
    logic                  res_end;
    logic                  res_used;
    t_status               res_status;
    logic                  mem_we;
    logic [BLK_W-1:0]      mem_addr;
    logic [NEXT_W-1:0]     mem_data;
    logic                  do_format;
    logic                  set_used;
    logic                  clr_used;
    logic                  cnt_dec;
    logic                  cnt_inc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_command;
            r_blk    <= i_block;
            r_tgt    <= i_link_target;
            r_is_end <= i_link_is_end;
        end
    end

    assign in_range = r_blk < IN_BLK_W'(NUM_BLOCKS);
    assign is_sys   = r_blk < IN_BLK_W'(FIRST_DATA_BLOCK);
    assign blk_a    = r_blk[BLK_W-1:0];

    // free data blocks, padded to whole groups
    always_comb begin
        free_vec = '0;
        for (int i = FIRST_DATA_BLOCK; i < NUM_BLOCKS; i++) begin
            free_vec[i] = ~r_used[i];
        end
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_any[g] = |free_vec[g*GRP_SIZE +: GRP_SIZE];
        end
        n_grp = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                n_grp = GRP_IDX_W'(g);
            end
        end
        n_any = |grp_any;
    end

    always_comb begin
        grp_bits = free_vec[r_grp*GRP_SIZE +: GRP_SIZE];
        pos      = '0;
        for (int p = GRP_SIZE - 1; p >= 0; p--) begin
            if (grp_bits[p]) begin
                pos = GRP_POS_W'(p);
            end
        end
        alloc_idx = BLK_W'({r_grp, pos});
    end

    always_comb begin
        if (r_vld[blk_a]) begin
            stored_next = r_rd_data;
        end else begin
            stored_next = is_sys ? END_VAL : '0;
        end
    end

    always_comb begin
        res_block  = '0;
        res_end    = 1'b0;
        res_used   = 1'b0;
        res_status = ST_OK;
        mem_we     = 1'b0;
        mem_addr   = blk_a;
        mem_data   = '0;
        do_format  = 1'b0;
        set_used   = 1'b0;
        clr_used   = 1'b0;
        cnt_dec    = 1'b0;
        cnt_inc    = 1'b0;
        case (r_cmd)
            CMD_FORMAT: begin
                do_format = 1'b1;
            end
            CMD_ALLOC: begin
                if (r_any) begin
                    res_block = RES_W'(alloc_idx);
                    mem_we    = 1'b1;
                    mem_addr  = alloc_idx;
                    mem_data  = END_VAL;
                    set_used  = 1'b1;
                    cnt_dec   = 1'b1;
                end else begin
                    res_status = ST_NOSPACE;
                end
            end
            CMD_FREE: begin
                if (is_sys || !in_range) begin
                    res_status = ST_RANGE;
                end else if (!r_used[blk_a]) begin
                    res_status = ST_FREE;
                end else begin
                    mem_we   = 1'b1;
                    clr_used = 1'b1;
                    cnt_inc  = 1'b1;
                end
            end
            CMD_LINK: begin
                if (!in_range) begin
                    res_status = ST_RANGE;
                end else begin
                    mem_we   = 1'b1;
                    mem_data = r_is_end ? END_VAL : NEXT_W'(r_tgt);
                end
            end
            CMD_NEXT: begin
                if (!in_range) begin
                    res_status = ST_RANGE;
                end else if (stored_next[END_BIT]) begin
                    res_end = 1'b1;
                end else begin
                    res_block = stored_next[RES_W-1:0];
                end
            end
            CMD_QUERY: begin
                if (!in_range) begin
                    res_status = ST_RANGE;
                end else begin
                    res_used = r_used[blk_a];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= USED_RESET;
            r_vld       <= '0;
            r_free_cnt  <= CNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.exec;
            if (i_ctl.exec) begin
                if (do_format) begin
                    r_used     <= USED_RESET;
                    r_vld      <= '0;
                    r_free_cnt <= CNT_RESET;
                end else begin
                    if (set_used) begin
                        r_used[mem_addr] <= 1'b1;
                    end
                    if (clr_used) begin
                        r_used[mem_addr] <= 1'b0;
                    end
                    if (mem_we) begin
                        r_vld[mem_addr] <= 1'b1;
                    end
                    if (cnt_dec && (r_free_cnt != '0)) begin
                        r_free_cnt <= r_free_cnt - CNT_W'(1);
                    end
                    if (cnt_inc && (r_free_cnt < CNT_MAX)) begin
                        r_free_cnt <= r_free_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && mem_we && !do_format) begin
            next_mem[mem_addr] <= mem_data;
        end
        if (i_ctl.lookup) begin
            r_rd_data <= next_mem[blk_a];
            r_grp     <= n_grp;
            r_any     <= n_any;
        end
        if (i_ctl.exec) begin
            r_res_block  <= res_block;
            r_res_end    <= res_end;
            r_res_used   <= res_used;
            r_res_status <= res_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_block  = r_res_block;
    assign o_result_is_end = r_res_end;
    assign o_used          = r_res_used;
    assign o_status        = r_res_status;
    assign o_free_count    = r_free_cnt;

    a_sys_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &r_used[FIRST_DATA_BLOCK-1:0])
        else $error("system block not marked used");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNT_RESET)
        else $error("free count above data block count");

    a_nospace_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res_status == ST_NOSPACE)) |-> (r_free_cnt == '0))
        else $error("no space reported with free blocks left");

    a_alloc_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && (r_cmd == CMD_ALLOC) && r_any)
        |=> (r_res_block >= RES_W'(FIRST_DATA_BLOCK)) && r_used[r_res_block[BLK_W-1:0]])
        else $error("allocated block is a system block or not marked used");

endmodule
`default_nettype wire

// ===== hw/rtl/fat_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat_block_allocator: file-allocation-table block allocator
// Used bitmap, chain pointers and free count with format, allocate, free,
// link, read-next and query-used commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item passes
// through a lookup cycle (next-pointer memory read and first-free group
// search) and an execute cycle (pick within the group, table write back).
// busy is high only in the lookup cycle and in reset, so a new item can be
// taken in the execute cycle of the last. The result appears on the cycle
// after the execute cycle, marked by o_valid for one cycle, and cannot be
// held off. Reset and format take effect at once, with no clearing pass.
module fat_block_allocator import fba_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [IN_BLK_W-1:0] i_block,
    input  wire logic [TGT_W-1:0]    i_link_target,
    input  wire logic                i_link_is_end,
    output logic                     o_valid,
    output logic [RES_W-1:0]         o_result_block,
    output logic                     o_result_is_end,
    output logic                     o_used,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_free_count
);

    t_dp_ctl ctl;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    fba_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_command       (i_command),
        .i_block         (i_block),
        .i_link_target   (i_link_target),
        .i_link_is_end   (i_link_is_end),
        .o_valid         (o_valid),
        .o_result_block  (o_result_block),
        .o_result_is_end (o_result_is_end),
        .o_used          (o_used),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule
`default_nettype wire
